[src/ecap_pkg.sv]
// Shared constants and codes for the edge trigger capture block.
`timescale 1ns / 1ps

package ecap_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 12;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FALLING_EDGE  = CFG_IDX_W'(1);

	// Request kinds
	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_CAPTURE = 1'b1;

	// Register reset values
	localparam logic [SAMPLE_W-1:0] TRIGGER_LEVEL_RST = SAMPLE_W'(2048);
	localparam logic                FALLING_EDGE_RST  = 1'b0;

	typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

[src/ecap_ifs.sv]
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps

interface ecap_req_if import ecap_pkg::*;;
	logic    valid;
	logic    ready;
	logic    kind;
	sample_t sample;

	modport source (output valid, output kind, output sample, input ready);
	modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface ecap_rsp_if import ecap_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t first_sample;
	sample_t second_sample;
	logic    trigger_found;
	logic    last;

	modport source (output valid, output first_sample, output second_sample,
		output trigger_found, output last, input ready);
	modport sink   (input valid, input first_sample, input second_sample,
		input trigger_found, input last, output ready);
endinterface

interface ecap_cfg_if import ecap_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/edge_trigger_capture.sv]
// Edge trigger capture: sample ring, backward edge search, windowed readout.
// Sample request: one per cycle while intake is open (idle), no response.
// Capture request: closes intake; the search reads one ring entry per cycle
//   until a hit or SEARCH_LIMIT steps; each response pair then passes S_RA, S_RB,
//   S_RC and waits in S_OUT on rsp.ready. The single ring read port paces both.
// Reset (arst_n low): registers to reset values, ring reads as zero until written.
`timescale 1ns / 1ps

module edge_trigger_capture import ecap_pkg::*; #(
	parameter int RING_DEPTH    = 2048,
	parameter int WINDOW_LENGTH = 128,
	parameter int SEARCH_LIMIT  = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	ecap_req_if.sink   req,
	ecap_rsp_if.source rsp,
	ecap_cfg_if.sink   cfg
);

	localparam int AW    = $clog2(RING_DEPTH);
	localparam int NW    = $clog2(SEARCH_LIMIT + 1);
	localparam int PAIRS = (WINDOW_LENGTH + 1) / 2;
	localparam int KW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam bit ODD_W = (WINDOW_LENGTH % 2) == 1;

	localparam logic [AW-1:0] LAST_IDX   = AW'(RING_DEPTH - 1);
	localparam logic [AW-1:0] HALF_BACK  = AW'(WINDOW_LENGTH / 2);
	localparam logic [AW-1:0] WIN_BACK   = AW'(WINDOW_LENGTH / 2 - 1);
	localparam logic [AW:0]   DEPTH_X    = (AW + 1)'(RING_DEPTH);
	localparam logic [AW:0]   FILL_FULL  = (AW + 1)'(RING_DEPTH);
	localparam logic [NW-1:0] LIMIT_N    = NW'(SEARCH_LIMIT);
	localparam logic [NW-1:0] LIMIT_LAST = NW'(SEARCH_LIMIT - 1);
	localparam logic [KW-1:0] PAIR_LAST  = KW'(PAIRS - 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_RA   = 3'd2;
	localparam logic [2:0] S_RB   = 3'd3;
	localparam logic [2:0] S_RC   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	// Step a ring index back by k entries, wrapping at RING_DEPTH.
	function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
			input logic [AW-1:0] k);
		logic [AW:0] wrapped;
		wrapped = {1'b0, p} + DEPTH_X - {1'b0, k};
		ring_back = (p >= k) ? (p - k) : wrapped[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		ring_inc = (p == LAST_IDX) ? '0 : (p + 1'b1);
	endfunction

	// Configuration registers
	sample_t lvl_q;
	logic    fall_q;

	// Ring bookkeeping: newest sample index and count of entries written so far
	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;

	// Sequencer
	logic [2:0]    st_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] iss_q;
	logic [NW-1:0] iss_n_q;
	logic          chk_vld_s1;
	logic [NW-1:0] chk_n_s1;
	logic [AW-1:0] chk_addr_s1;
	sample_t       prev_q;
	logic [AW-1:0] rp_q;
	logic [KW-1:0] k_q;
	logic          found_q;
	sample_t       a_q;

	// Response register
	logic    out_vld_q;
	sample_t out_first_q;
	sample_t out_second_q;
	logic    out_found_q;
	logic    out_last_q;

	// Ring memory and its registered read port
	sample_t       ring_mem [RING_DEPTH];
	sample_t       rd_q;
	logic          rd_vld_q;
	logic [AW-1:0] ra;
	logic [AW-1:0] ra_off;
	logic          ra_written;
	logic          we;
	logic [AW-1:0] wp_nxt;
	sample_t       rd_data;

	logic          req_acc;
	logic          issue;
	logic          hit;
	logic          give_up;
	logic [AW-1:0] centre;

	assign req.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign we        = req_acc && (req.kind == KIND_SAMPLE);
	assign wp_nxt    = ring_inc(wp_q);

	// Drive read address: search pointer while searching, window pointer otherwise.
	assign ra = (st_q == S_SRCH) ? iss_q : rp_q;

	// Entries are written in order starting at index 1; an entry holds data
	// once its offset from index 1 falls below the fill count.
	assign ra_off     = (ra == '0) ? LAST_IDX : (ra - 1'b1);
	assign ra_written = ({1'b0, ra_off} < fill_q);
	assign rd_data    = rd_vld_q ? rd_q : '0;

	// Keep issuing reads until SEARCH_LIMIT entries have been requested.
	assign issue = (st_q == S_SRCH) && (iss_n_q < LIMIT_N);

	// Edge test: prev_q is the later sample, rd_data the earlier one.
	// The first step compares the start entry with itself and never hits.
	always_comb begin
		hit = 1'b0;
		if (chk_n_s1 != '0) begin
			if (fall_q) begin
				hit = (prev_q < lvl_q) && (rd_data >= lvl_q);
			end else begin
				hit = (prev_q > lvl_q) && (rd_data <= lvl_q);
			end
		end
	end

	assign give_up = (chk_n_s1 == LIMIT_LAST);
	assign centre  = hit ? chk_addr_s1 : start_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[wp_nxt] <= req.sample;
		end
		rd_q     <= ring_mem[ra];
		rd_vld_q <= ra_written;
	end

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= TRIGGER_LEVEL_RST;
			fall_q <= FALLING_EDGE_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_TRIGGER_LEVEL) begin
				lvl_q <= cfg.data[SAMPLE_W-1:0];
			end else if (cfg.index == REG_FALLING_EDGE) begin
				fall_q <= cfg.data[0];
			end
		end
	end

	// Advance the write pointer and saturate the fill count on each sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (we) begin
			wp_q <= wp_nxt;
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Search read pipeline: tag each issued read with its step and address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		chk_n_s1    <= iss_n_q;
		chk_addr_s1 <= iss_q;
	end

	// Sequencer: search, then read the window out a pair at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			out_vld_q <= 1'b0;
			iss_n_q   <= '0;
			k_q       <= '0;
			found_q   <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (req_acc && (req.kind == KIND_CAPTURE)) begin
						start_q <= ring_back(wp_q, HALF_BACK);
						iss_q   <= ring_back(wp_q, HALF_BACK);
						iss_n_q <= '0;
						k_q     <= '0;
						st_q    <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (issue) begin
						iss_q   <= ring_back(iss_q, AW'(1));
						iss_n_q <= iss_n_q + 1'b1;
					end
					if (chk_vld_s1) begin
						prev_q <= rd_data;
						if (hit || give_up) begin
							found_q <= hit;
							rp_q    <= ring_back(centre, WIN_BACK);
							st_q    <= S_RA;
						end
					end
				end
				S_RA: begin
					rp_q <= ring_inc(rp_q);
					st_q <= S_RB;
				end
				S_RB: begin
					a_q  <= rd_data;
					rp_q <= ring_inc(rp_q);
					st_q <= S_RC;
				end
				S_RC: begin
					out_first_q  <= a_q;
					// Odd window: the final pair has no later sample.
					out_second_q <= (ODD_W && (k_q == PAIR_LAST)) ? '0 : rd_data;
					out_found_q  <= found_q;
					out_last_q   <= (k_q == PAIR_LAST);
					out_vld_q    <= 1'b1;
					st_q         <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						out_vld_q <= 1'b0;
						if (out_last_q) begin
							st_q <= S_IDLE;
						end else begin
							k_q  <= k_q + 1'b1;
							st_q <= S_RA;
						end
					end
				end
				default: begin
					st_q      <= S_IDLE;
					out_vld_q <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.first_sample  = out_first_q;
	assign rsp.second_sample = out_second_q;
	assign rsp.trigger_found = out_found_q;
	assign rsp.last          = out_last_q;

endmodule

[src/ecap_checker.sv]
// Port-level assertions for the edge trigger capture block, bound to the top level.
`timescale 1ns / 1ps

module ecap_checker import ecap_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    req_valid,
	input logic    req_ready,
	input logic    req_kind,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input sample_t rsp_first_sample,
	input sample_t rsp_second_sample,
	input logic    rsp_trigger_found,
	input logic    rsp_last
);

	// Intake is closed while a response is pending.
	a_no_intake_during_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request ready while a response is pending");

	// A capture request closes intake on the next cycle.
	a_capture_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_kind == KIND_CAPTURE)) |=> !req_ready)
		else $error("intake stayed open after a capture request");

	// The final pair ends the window: no response directly after it.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && rsp_last) |=> !rsp_valid)
		else $error("response after the final pair");

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_first_sample)
			&& $stable(rsp_second_sample) && $stable(rsp_trigger_found)
			&& $stable(rsp_last)))
		else $error("stalled response changed");

endmodule

bind edge_trigger_capture ecap_checker u_ecap_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_kind          (req.kind),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_first_sample  (rsp.first_sample),
	.rsp_second_sample (rsp.second_sample),
	.rsp_trigger_found (rsp.trigger_found),
	.rsp_last          (rsp.last)
);

[verif/tb_top.sv]
// Self-checking testbench for the edge trigger capture block.
`timescale 1ns / 1ps

module tb_top;
	import ecap_pkg::*;

	localparam int RING_DEPTH      = 2048;
	localparam int WINDOW_LENGTH   = 128;
	localparam int SEARCH_LIMIT    = 1024;
	localparam int PTR_W           = $clog2(RING_DEPTH);
	localparam int PAIRS           = (WINDOW_LENGTH + 1) / 2;
	localparam int PHASE_COUNT     = 8;
	localparam int ITEMS_PER_PHASE = 42;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 32;
	// A missed search walks SEARCH_LIMIT entries with nothing moving on any
	// channel; allow that plus long receiver stalls many times over.
	localparam int QUIET_LIMIT     = 20000;
	localparam int MAX_REPORTS     = 10;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_SQUARE,
		SHAPE_RAMP,
		SHAPE_FLAT,
		SHAPE_RAIL
	} wave_shape_t;

	typedef struct packed {
		logic    kind;
		sample_t sample;
	} capture_req_t;

	typedef struct packed {
		sample_t first_sample;
		sample_t second_sample;
		logic    trigger_found;
		logic    last;
	} window_pair_t;

	logic clk;
	logic arst_n;

	ecap_req_if req_ch ();
	ecap_rsp_if rsp_ch ();
	ecap_cfg_if cfg_ch ();

	edge_trigger_capture #(
		.RING_DEPTH   (RING_DEPTH),
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.SEARCH_LIMIT (SEARCH_LIMIT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Requests waiting for the driver, and response pairs still owed by the block
	capture_req_t pending_reqs[$];
	window_pair_t expected_pairs[$];

	// Shadow copy of the block state, advanced on every accepted request
	sample_t          shadow_ring [RING_DEPTH];
	logic [PTR_W-1:0] shadow_head;
	sample_t          shadow_level;
	logic             shadow_falling;

	// Per-phase idling, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;

	int mismatches     = 0;
	int pairs_checked  = 0;
	int samples_taken  = 0;
	int captures_taken = 0;
	int triggers_found = 0;
	int quiet_cycles   = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predict one accepted request: store a sample, or search and read out a window.
	task automatic predict_request(input capture_req_t rq);
		logic [PTR_W-1:0] start_ptr;
		logic [PTR_W-1:0] ptr;
		sample_t          prev_s;
		sample_t          cur_s;
		logic             hit;
		window_pair_t     pr;
		int               n;
		int               k;
		if (rq.kind == KIND_SAMPLE) begin
			// Advance first, then store: the head always names the newest sample
			shadow_head = shadow_head + 1'b1;
			shadow_ring[shadow_head] = rq.sample;
			samples_taken++;
		end else begin
			captures_taken++;
			start_ptr = shadow_head - PTR_W'(WINDOW_LENGTH / 2);
			ptr = start_ptr;
			prev_s = shadow_ring[ptr];
			hit = 1'b0;
			// Walk backward; prev_s is the later sample, cur_s the earlier one.
			// The first step compares the start entry with itself and never hits.
			for (n = 0; n < SEARCH_LIMIT && !hit; n++) begin
				cur_s = shadow_ring[ptr];
				if (shadow_falling)
					hit = (prev_s < shadow_level) && (cur_s >= shadow_level);
				else
					hit = (prev_s > shadow_level) && (cur_s <= shadow_level);
				if (!hit) begin
					prev_s = cur_s;
					ptr = ptr - 1'b1;
				end
			end
			// On a miss, centre the window on the start point
			if (!hit)
				ptr = start_ptr;
			else
				triggers_found++;
			ptr = ptr - PTR_W'(WINDOW_LENGTH / 2 - 1);
			for (k = 0; k < PAIRS; k++) begin
				pr.first_sample = shadow_ring[ptr];
				ptr = ptr + 1'b1;
				pr.second_sample = '0;
				if (2 * k + 1 < WINDOW_LENGTH) begin
					pr.second_sample = shadow_ring[ptr];
					ptr = ptr + 1'b1;
				end
				pr.trigger_found = hit;
				pr.last = (k == PAIRS - 1);
				expected_pairs.push_back(pr);
			end
		end
	endtask

	function automatic void note_mismatch(input string what, input window_pair_t want,
		input window_pair_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display({"%t %s: expected first=%0d second=%0d found=%0b last=%0b,",
				" got first=%0d second=%0d found=%0b last=%0b"},
				$realtime, what, want.first_sample, want.second_sample, want.trigger_found,
				want.last, got.first_sample, got.second_sample, got.trigger_found, got.last);
	endfunction

	task automatic queue_request(input logic kind, input sample_t smp);
		capture_req_t rq;
		rq.kind = kind;
		rq.sample = smp;
		pending_reqs.push_back(rq);
	endtask

	// Write one register; call only while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_TRIGGER_LEVEL)
			shadow_level = val[SAMPLE_W-1:0];
		else if (idx == REG_FALLING_EDGE)
			shadow_falling = val[0];
	endtask

	// Wait until every request is taken and every pair has come back, then settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_pairs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Request driver: hold a request until it is taken, then offer the next one
	// or idle for a cycle at the phase's rate. Predict each request as it is taken.
	always @(posedge clk or negedge arst_n) begin : request_driver
		capture_req_t nxt;
		capture_req_t taken;
		int           i;
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.kind   <= KIND_SAMPLE;
			req_ch.sample <= '0;
			for (i = 0; i < RING_DEPTH; i++)
				shadow_ring[i] = '0;
			shadow_head    = '0;
			shadow_level   = TRIGGER_LEVEL_RST;
			shadow_falling = FALLING_EDGE_RST;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				taken.kind = req_ch.kind;
				taken.sample = req_ch.sample;
				predict_request(taken);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid  <= 1'b1;
					req_ch.kind   <= nxt.kind;
					req_ch.sample <= nxt.sample;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check each taken pair against the oldest expected one,
	// and stall the block at the phase's rate.
	always @(posedge clk or negedge arst_n) begin : response_monitor
		window_pair_t got;
		window_pair_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.first_sample  = rsp_ch.first_sample;
				got.second_sample = rsp_ch.second_sample;
				got.trigger_found = rsp_ch.trigger_found;
				got.last          = rsp_ch.last;
				if (expected_pairs.size() == 0) begin
					note_mismatch("response with nothing expected", '0, got);
				end else begin
					want = expected_pairs.pop_front();
					pairs_checked++;
					if (got.first_sample !== want.first_sample
						|| got.second_sample !== want.second_sample
						|| got.trigger_found !== want.trigger_found
						|| got.last !== want.last)
						note_mismatch("response mismatch", want, got);
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run when no channel has moved for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		wave_shape_t shape;
		sample_t     lvl;
		int          phase;
		int          count;
		int          room;
		int          half;
		int          amp;
		int          step;
		int          base;
		int          val;
		int          i;
		logic [CFG_DATA_W-1:0] level_val;
		logic        fall_val;

		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset register values: capture from a cleared ring (a miss
		// whose window wraps below index zero), rail and level-boundary samples,
		// back-to-back captures, and a capture whose sample field is ignored.
		queue_request(KIND_CAPTURE, 12'hFFF);
		queue_request(KIND_SAMPLE, 12'd0);
		queue_request(KIND_SAMPLE, 12'd4095);
		queue_request(KIND_SAMPLE, 12'd2048);
		queue_request(KIND_SAMPLE, 12'd2047);
		queue_request(KIND_SAMPLE, 12'd2049);
		queue_request(KIND_SAMPLE, 12'd2048);
		queue_request(KIND_SAMPLE, 12'd1);
		queue_request(KIND_SAMPLE, 12'd4094);
		queue_request(KIND_SAMPLE, 12'hAAA);
		queue_request(KIND_SAMPLE, 12'h555);
		queue_request(KIND_SAMPLE, 12'd0);
		queue_request(KIND_SAMPLE, 12'd4095);
		queue_request(KIND_CAPTURE, 12'd0);
		queue_request(KIND_CAPTURE, 12'h5A5);
		queue_request(KIND_SAMPLE, 12'd2048);
		queue_request(KIND_CAPTURE, 12'hFFF);
		wait_idle();

		// Random phases: each sets both registers, then sends bursts of shaped
		// samples followed by a capture, mixed with short runs of raw noise.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin level_val = 12'd2048; fall_val = 1'b0; end
				1: begin level_val = 12'd0;    fall_val = 1'b1; end  // falling never hits
				2: begin level_val = 12'd0;    fall_val = 1'b0; end
				3: begin level_val = 12'd4095; fall_val = 1'b1; end
				4: begin level_val = 12'd4095; fall_val = 1'b0; end  // rising never hits
				default: begin
					level_val = CFG_DATA_W'($urandom);
					fall_val  = 1'($urandom_range(1));
				end
			endcase
			write_reg(REG_TRIGGER_LEVEL, level_val);
			// Upper data bits are don't-care for the edge select; toggle them anyway
			write_reg(REG_FALLING_EDGE, {(CFG_DATA_W - 1)'($urandom), fall_val});
			@(negedge clk);

			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 56; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 56; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase

			lvl = shadow_level;
			while (pending_reqs.size() < ITEMS_PER_PHASE) begin
				room = ITEMS_PER_PHASE - pending_reqs.size();
				if ($urandom_range(99) < 85) begin
					shape = wave_shape_t'($urandom_range(SHAPE_RAIL, SHAPE_NOISE));
					count = $urandom_range(60, 2);
					if (count > room)
						count = room;
					half  = $urandom_range(20, 1);
					amp   = $urandom_range(400, 0);
					step  = $urandom_range(200, 1);
					base  = $urandom_range(4095, 0);
					if (shape == SHAPE_FLAT && $urandom_range(1))
						base = lvl;  // sit exactly on the level
					for (i = 0; i < count; i++) begin
						case (shape)
							SHAPE_NOISE:  val = $urandom_range(4095, 0);
							SHAPE_SQUARE: val = ((i / half) % 2) ? lvl + amp : lvl - amp;
							SHAPE_RAMP:   val = (base + i * step) % 4096;
							SHAPE_FLAT:   val = base;
							default:      val = $urandom_range(1) ? 4095 : 0;
						endcase
						if (val < 0)
							val = 0;
						else if (val > 4095)
							val = 4095;
						queue_request(KIND_SAMPLE, sample_t'(val));
					end
					queue_request(KIND_CAPTURE, sample_t'($urandom));
					if ($urandom_range(9) == 0)
						queue_request(KIND_CAPTURE, sample_t'($urandom));
				end else begin
					count = $urandom_range(6, 1);
					if (count > room)
						count = room;
					for (i = 0; i < count; i++)
						queue_request(1'($urandom_range(1)), sample_t'($urandom));
				end
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_pairs.size() != 0)
			$display("%0d expected response pairs never arrived", expected_pairs.size());
		$display("Covered %0d samples and %0d captures (%0d with a trigger hit), %0d pairs checked",
			samples_taken, captures_taken, triggers_found, pairs_checked);
		$display("over %0d register settings with sender gaps and receiver stalls; %0d mismatches",
			PHASE_COUNT + 1, mismatches);
		if (mismatches == 0 && expected_pairs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[files.f]
src/ecap_pkg.sv
src/ecap_ifs.sv
src/edge_trigger_capture.sv
src/ecap_checker.sv
verif/tb_top.sv
